/* src/assert_macros.svh */
// ------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers with and without a reset guard.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge, held off during reset
`define KRT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// check a property on every rising edge, reset included
`define KRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/krt_pkg.sv */
// ------------------------------------------------------------------------
// krt_pkg
// Item types, codes and helpers shared by the keyed record table.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package krt_pkg;

	localparam int NAME_BYTES  = 25;
	localparam int NAME_BITS   = NAME_BYTES * 8;
	localparam int MAX_RESULTS = 32;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_SEARCH = 2'd1,
		MODE_UPDATE = 2'd2,
		MODE_LIST   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic signed [31:0] part_key;
		logic [63:0]        name_word_0;
		logic [63:0]        name_word_1;
		logic [63:0]        name_word_2;
		logic [7:0]         name_word_3;
		logic signed [31:0] amount;
	} req_item_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] out_key;
		logic [63:0]        out_name_0;
		logic [63:0]        out_name_1;
		logic [63:0]        out_name_2;
		logic [7:0]         out_name_3;
		logic signed [31:0] out_quantity;
		logic               last;
	} rsp_item_t;

	typedef struct packed {
		logic [31:0]          key;
		logic [NAME_BITS-1:0] name;
		logic [31:0]          quantity;
	} rec_t;

	typedef struct packed {
		logic rd_valid;
		logic first_pass;
		logic best_valid;
		logic list_mode;
	} scan_ctl_t;

	typedef struct packed {
		logic hit;
		logic better;
	} scan_res_t;

	// zero every character after the first zero or beyond the name length
	function automatic logic [NAME_BITS-1:0] mask_name(logic [NAME_BITS-1:0] raw,
	                                                   int unsigned nchars);
		logic [NAME_BITS-1:0] res;
		logic                 ended;
		res   = '0;
		ended = 1'b0;
		for (int unsigned i = 0; i < NAME_BYTES; i++) begin
			if (i >= nchars || raw[i*8 +: 8] == 8'd0)
				ended = 1'b1;
			if (!ended)
				res[i*8 +: 8] = raw[i*8 +: 8];
		end
		return res;
	endfunction

	function automatic rsp_item_t rec_rsp(rec_t r, logic last);
		rsp_item_t o;
		o.status       = ST_OK;
		o.out_key      = r.key;
		o.out_name_0   = r.name[63:0];
		o.out_name_1   = r.name[127:64];
		o.out_name_2   = r.name[191:128];
		o.out_name_3   = r.name[199:192];
		o.out_quantity = r.quantity;
		o.last         = last;
		return o;
	endfunction

	function automatic rsp_item_t refuse_rsp(status_t st, logic [31:0] key);
		rsp_item_t o;
		o         = '0;
		o.status  = st;
		o.out_key = key;
		o.last    = 1'b1;
		return o;
	endfunction

endpackage

/* src/keyed_record_table.sv */
// Keyed record table: linear-scan store of up to CAPACITY records, n of them held.
// Insert, search, update: scan reads over the n records and drain, decide, load output;
// a new item is taken only once its result is loaded. Insert to a full table: no scan.
// List: one scan pass per record, up to MAX_RESULTS records, none when empty. A stalled
// output holds the sequencer until the slot frees.
// Reset empties the table at once; record contents stay undefined until written.
// ------------------------------------------------------------------------
// keyed_record_table
// Sequencer around the record store and the shared key comparator.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyed_record_table import krt_pkg::*; #(
	parameter int CAPACITY   = 32,
	parameter int NAME_CHARS = 25
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DECIDE = 4'b0100,
		S_EMIT   = 4'b1000
	} state_t;

	state_t      state_q;
	req_item_t   item_q;
	req_item_t   req_m;
	logic [CW-1:0] count_q, addr_q, k_q, emit_n;
	logic        rvalid_s1;
	logic [AW-1:0] ridx_s1, fidx_q;
	logic        found_q, best_valid_q;
	logic [31:0] best_v_q, prev_q;
	rec_t        rec_q, rd_data, wdata;
	rsp_item_t   res_q, rsp_q;
	logic        rsp_valid_q;
	logic        we;
	logic [AW-1:0] waddr;
	logic [32:0] sum;
	logic [31:0] sat;
	logic        slot_free, accept;
	logic [NAME_BITS-1:0] name_m;
	scan_ctl_t   ctl;
	scan_res_t   cmp;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	assign name_m = mask_name({req.name_word_3, req.name_word_2, req.name_word_1,
	                           req.name_word_0}, NAME_CHARS);

	always_comb begin
		req_m             = req;
		req_m.name_word_0 = name_m[63:0];
		req_m.name_word_1 = name_m[127:64];
		req_m.name_word_2 = name_m[191:128];
		req_m.name_word_3 = name_m[199:192];
	end

	assign emit_n = (32'(count_q) > MAX_RESULTS) ? CW'(MAX_RESULTS) : count_q;

	assign sum = {rec_q.quantity[31], rec_q.quantity} + {item_q.amount[31], item_q.amount};
	assign sat = (sum[32] != sum[31]) ? (sum[32] ? 32'h8000_0000 : 32'h7fff_ffff)
	                                  : sum[31:0];

	assign ctl.rd_valid   = rvalid_s1 && (state_q == S_SCAN);
	assign ctl.first_pass = (k_q == '0);
	assign ctl.best_valid = best_valid_q;
	assign ctl.list_mode  = (item_q.mode == MODE_LIST);

	krt_unit u_unit (
		.ctl     (ctl),
		.rd_key  (rd_data.key),
		.ref_key (item_q.part_key),
		.prev_v  (prev_q),
		.best_v  (best_v_q),
		.res     (cmp)
	);

	always_comb begin
		we             = 1'b0;
		waddr          = count_q[AW-1:0];
		wdata.key      = item_q.part_key;
		wdata.name     = {item_q.name_word_3, item_q.name_word_2, item_q.name_word_1,
		                  item_q.name_word_0};
		wdata.quantity = item_q.amount;
		if (state_q == S_DECIDE) begin
			if (item_q.mode == MODE_INSERT && !found_q)
				we = 1'b1;
			if (item_q.mode == MODE_UPDATE && found_q) begin
				we             = 1'b1;
				waddr          = fidx_q;
				wdata          = rec_q;
				wdata.quantity = sat;
			end
		end
	end

	krt_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (addr_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			addr_q       <= '0;
			k_q          <= '0;
			rvalid_s1    <= 1'b0;
			found_q      <= 1'b0;
			best_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_EMIT)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q       <= '0;
						k_q          <= '0;
						found_q      <= 1'b0;
						best_valid_q <= 1'b0;
						rvalid_s1    <= 1'b0;
						if (req.mode == MODE_INSERT && count_q == CW'(CAPACITY))
							state_q <= S_EMIT;
						else if (req.mode == MODE_LIST && count_q == '0)
							state_q <= S_IDLE;
						else
							state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rvalid_s1 <= (addr_q < count_q);
					if (addr_q < count_q)
						addr_q <= addr_q + CW'(1);
					if (cmp.hit)
						found_q <= 1'b1;
					if (cmp.better)
						best_valid_q <= 1'b1;
					if (addr_q == count_q && !rvalid_s1)
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (item_q.mode == MODE_INSERT && !found_q)
						count_q <= count_q + CW'(1);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						if (item_q.mode == MODE_LIST && !res_q.last) begin
							k_q          <= k_q + CW'(1);
							addr_q       <= '0;
							best_valid_q <= 1'b0;
							rvalid_s1    <= 1'b0;
							state_q      <= S_SCAN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= addr_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q <= req_m;
					res_q  <= refuse_rsp(ST_FULL, req.part_key);
				end
			end
			S_SCAN: begin
				if (cmp.hit) begin
					fidx_q <= ridx_s1;
					rec_q  <= rd_data;
				end
				if (cmp.better) begin
					best_v_q <= rd_data.key ^ 32'h8000_0000;
					rec_q    <= rd_data;
				end
			end
			S_DECIDE: begin
				case (item_q.mode)
					MODE_INSERT: begin
						if (found_q)
							res_q <= refuse_rsp(ST_DUPLICATE, item_q.part_key);
						else
							res_q <= rec_rsp(wdata, 1'b1);
					end
					MODE_SEARCH: begin
						if (found_q)
							res_q <= rec_rsp(rec_q, 1'b1);
						else
							res_q <= refuse_rsp(ST_NOT_FOUND, item_q.part_key);
					end
					MODE_UPDATE: begin
						if (found_q)
							res_q <= rec_rsp(wdata, 1'b1);
						else
							res_q <= refuse_rsp(ST_NOT_FOUND, item_q.part_key);
					end
					MODE_LIST: begin
						res_q  <= rec_rsp(rec_q, CW'(k_q + CW'(1)) == emit_n);
						prev_q <= best_v_q;
					end
					default: res_q <= refuse_rsp(ST_NOT_FOUND, item_q.part_key);
				endcase
			end
			S_EMIT: begin
				if (slot_free)
					rsp_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	`KRT_ASSERT_ALWAYS(a_count_bound, clk, 32'(count_q) <= CAPACITY, "entry count beyond capacity")
	`KRT_ASSERT(a_insert_grows, clk, arst_n, (state_q == S_DECIDE && item_q.mode == MODE_INSERT && !found_q) |=> (count_q == $past(count_q) + CW'(1)), "insert did not grow table")
	`KRT_ASSERT(a_list_found, clk, arst_n, (state_q == S_DECIDE && item_q.mode == MODE_LIST) |-> best_valid_q, "list pass found no record")
	`KRT_ASSERT(a_list_order, clk, arst_n, (state_q == S_DECIDE && item_q.mode == MODE_LIST && k_q != '0) |-> (best_v_q > prev_q), "list keys out of order")

endmodule

/* src/krt_mem.sv */
// ------------------------------------------------------------------------
// krt_mem
// Record store: one write port, one registered read port.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module krt_mem import krt_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  rec_t          wdata,
	input  logic [AW-1:0] raddr,
	output rec_t          rdata
);

	rec_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

/* src/krt_unit.sv */
// ------------------------------------------------------------------------
// krt_unit
// Shared key comparator: match test and sorted selection test.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module krt_unit import krt_pkg::*; (
	input  scan_ctl_t   ctl,
	input  logic [31:0] rd_key,
	input  logic [31:0] ref_key,
	input  logic [31:0] prev_v,
	input  logic [31:0] best_v,
	output scan_res_t   res
);

	logic [31:0] v;

	// bias the sign bit so that an unsigned compare orders signed keys
	assign v          = rd_key ^ 32'h8000_0000;
	assign res.hit    = ctl.rd_valid && !ctl.list_mode && (rd_key == ref_key);
	assign res.better = ctl.rd_valid && ctl.list_mode
	                    && (ctl.first_pass || v > prev_v)
	                    && (!ctl.best_valid || v < best_v);

endmodule
